/* design/lmrws_pkg.sv */
package lmrws_pkg;

  localparam logic [7:0] UNLOCK_REG   = 8'hFE;
  localparam logic [7:0] UNLOCK_KEY   = 8'hC5;
  localparam logic [7:0] PAGE_SEL_REG = 8'hFD;

  localparam logic [8:0] LED_COUNT     = 9'd351;
  localparam logic [8:0] LOW_BANK_SIZE = 9'd180;
  localparam logic [3:0] MAX_COLUMN    = 4'd12;
  localparam logic [3:0] MAX_ROW       = 4'd8;
  localparam logic [3:0] NARROW_COLS   = 4'd10;
  localparam logic [6:0] WIDE_BASE     = 7'd80;

  localparam logic [2:0] PAGE_PWM_LO = 3'd0;
  localparam logic [2:0] PAGE_PWM_HI = 3'd1;
  localparam logic [2:0] PAGE_SCL_LO = 3'd2;
  localparam logic [2:0] PAGE_SCL_HI = 3'd3;
  localparam logic [2:0] PAGE_CONFIG = 3'd4;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_RAW   = 1'b1;

  localparam logic [1:0] COLOR_RED  = 2'd0;
  localparam logic [1:0] COLOR_NONE = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UNLOCK1,
    ST_SEL1,
    ST_PWM,
    ST_UNLOCK2,
    ST_SEL2,
    ST_SCALE,
    ST_SINGLE
  } step_t;

  // decoded form of one request
  typedef struct packed {
    logic       err;
    logic       empty;
    logic       high;
    logic [7:0] addr;
  } map_t;

  function automatic logic [3:0] row_perm(input logic [3:0] row);
    logic [3:0] r;
    case (row)
      4'd0: r = 4'd8;
      4'd1: r = 4'd5;
      4'd2: r = 4'd4;
      4'd3: r = 4'd3;
      4'd4: r = 4'd2;
      4'd5: r = 4'd1;
      4'd6: r = 4'd0;
      4'd7: r = 4'd7;
      4'd8: r = 4'd6;
      default: r = 4'd0;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] swap_pos(input logic [1:0] pos);
    logic [1:0] p;
    case (pos)
      2'd0: p = 2'd2;
      2'd1: p = 2'd0;
      2'd2: p = 2'd1;
      default: p = 2'd0;
    endcase
    return p;
  endfunction

endpackage

/* design/lmrws_req_if.sv */
interface lmrws_req_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [3:0] column;
  logic [3:0] row;
  logic [1:0] color;
  logic [7:0] brightness;
  logic [8:0] led_index;
  logic [7:0] pwm_level;
  logic [7:0] current_scale;

  modport source (
    output valid, op, column, row, color, brightness, led_index, pwm_level, current_scale,
    input  ready
  );
  modport sink (
    input  valid, op, column, row, color, brightness, led_index, pwm_level, current_scale,
    output ready
  );
endinterface

/* design/lmrws_rsp_if.sv */
interface lmrws_rsp_if;
  logic       valid;
  logic       ready;
  logic       write_valid;
  logic [7:0] reg_addr;
  logic [7:0] reg_data;
  logic       error;
  logic       last;

  modport source (
    output valid, write_valid, reg_addr, reg_data, error, last,
    input  ready
  );
  modport sink (
    input  valid, write_valid, reg_addr, reg_data, error, last,
    output ready
  );
endinterface

/* design/lmrws_led_map.sv */
module lmrws_led_map (
  input  logic                op,
  input  logic [3:0]          column,
  input  logic [3:0]          row,
  input  logic [1:0]          color,
  input  logic [8:0]          led_index,
  output lmrws_pkg::map_t     map
);

  logic [3:0] prow;
  logic [6:0] slot;
  logic [8:0] base;
  logic [1:0] pos;
  logic [1:0] pos_sw;
  logic [8:0] idx;
  logic       high;

  always_comb begin
    prow = lmrws_pkg::row_perm(row);
    if (column < lmrws_pkg::NARROW_COLS) begin
      slot = {3'b000, column} + {3'b000, prow} * 7'd10;
    end else begin
      slot = {3'b000, column} + lmrws_pkg::WIDE_BASE + {3'b000, prow} * 7'd3;
    end
    base = {2'b00, slot} * 9'd3;
    pos  = 2'd2 - color;
    // odd columns and the last column have red, green and blue rotated by one position
    if (column[0] || column == lmrws_pkg::MAX_COLUMN) begin
      pos_sw = lmrws_pkg::swap_pos(pos);
    end else begin
      pos_sw = pos;
    end

    if (op == lmrws_pkg::OP_PIXEL) begin
      idx       = base + {7'd0, pos_sw};
      map.err   = (column > lmrws_pkg::MAX_COLUMN) || (row > lmrws_pkg::MAX_ROW);
      map.empty = (color == lmrws_pkg::COLOR_NONE);
    end else begin
      idx       = led_index;
      map.err   = (led_index >= lmrws_pkg::LED_COUNT);
      map.empty = 1'b0;
    end

    high     = (idx >= lmrws_pkg::LOW_BANK_SIZE);
    map.high = high;
    map.addr = high ? 8'(idx - lmrws_pkg::LOW_BANK_SIZE) : idx[7:0];
  end

endmodule

/* design/led_matrix_register_write_sequencer_unit.sv */
// Path: a request taken into the input stage is loaded into the sequencer state when the
// sequencer is idle, and its first register write is then registered into the output register.
// Throughput: one result word per cycle unless the result side stalls; a write request
// yields 6 words (the tracked page is always a scale page after a write, so both page changes
// go out), an error or empty request 1 word; the next request loads only with the last word.
// Reset (synchronous, rst high) empties all stages and sets the tracked page to 4.
module led_matrix_register_write_sequencer_unit (
  input logic         clk,
  input logic         rst,
  lmrws_req_if.sink   req,
  lmrws_rsp_if.source rsp
);

  // input stage
  logic       in_full;
  logic       in_op;
  logic [3:0] in_column;
  logic [3:0] in_row;
  logic [1:0] in_color;
  logic [7:0] in_brightness;
  logic [8:0] in_led_index;
  logic [7:0] in_pwm;
  logic [7:0] in_scl;

  lmrws_pkg::map_t dec;

  // sequencer
  lmrws_pkg::step_t state;
  lmrws_pkg::step_t state_next;
  lmrws_pkg::step_t first_step;
  logic [2:0] current_page;
  logic       p_err;
  logic       p_high;
  logic [7:0] p_addr;
  logic [7:0] p_pwm;
  logic [7:0] p_scl;

  logic       out_adv;
  logic       emit;
  logic       load;
  logic       at_last;
  logic [2:0] pwm_page;
  logic [2:0] scl_page;

  logic       w_valid;
  logic [7:0] w_addr;
  logic [7:0] w_data;
  logic       w_error;
  logic       w_last;

  lmrws_led_map u_map (
    .op        (in_op),
    .column    (in_column),
    .row       (in_row),
    .color     (in_color),
    .led_index (in_led_index),
    .map       (dec)
  );

  assign out_adv   = !rsp.valid || rsp.ready;
  assign emit      = (state != lmrws_pkg::ST_IDLE) && out_adv;
  assign at_last   = (state == lmrws_pkg::ST_SCALE) || (state == lmrws_pkg::ST_SINGLE);
  assign load      = in_full && ((state == lmrws_pkg::ST_IDLE) || (emit && at_last));
  assign req.ready = !in_full || load;

  assign pwm_page = dec.high ? lmrws_pkg::PAGE_PWM_HI : lmrws_pkg::PAGE_PWM_LO;
  assign scl_page = dec.high ? lmrws_pkg::PAGE_SCL_HI : lmrws_pkg::PAGE_SCL_LO;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (req.valid && req.ready) begin
      in_full <= 1'b1;
    end else if (load) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      in_op         <= req.op;
      in_column     <= req.column;
      in_row        <= req.row;
      in_color      <= req.color;
      in_brightness <= req.brightness;
      in_led_index  <= req.led_index;
      in_pwm        <= req.pwm_level;
      in_scl        <= req.current_scale;
    end
  end

  always_comb begin
    if (dec.err || dec.empty) begin
      first_step = lmrws_pkg::ST_SINGLE;
    end else if (current_page != pwm_page) begin
      first_step = lmrws_pkg::ST_UNLOCK1;
    end else begin
      first_step = lmrws_pkg::ST_PWM;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= lmrws_pkg::ST_IDLE;
      current_page <= lmrws_pkg::PAGE_CONFIG;
    end else begin
      state <= state_next;
      // the scale write always ends on the scale page
      if (load && !dec.err && !dec.empty) begin
        current_page <= scl_page;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      p_err  <= dec.err;
      p_high <= dec.high;
      p_addr <= dec.addr;
      p_pwm  <= (in_op == lmrws_pkg::OP_PIXEL) ? in_brightness : in_pwm;
      p_scl  <= (in_op == lmrws_pkg::OP_PIXEL) ? in_brightness : in_scl;
    end
  end

  always_comb begin
    state_next = state;
    w_valid    = 1'b1;
    w_addr     = 8'd0;
    w_data     = 8'd0;
    w_error    = 1'b0;
    w_last     = 1'b0;
    case (state)
      lmrws_pkg::ST_UNLOCK1, lmrws_pkg::ST_UNLOCK2: begin
        w_addr = lmrws_pkg::UNLOCK_REG;
        w_data = lmrws_pkg::UNLOCK_KEY;
      end
      lmrws_pkg::ST_SEL1: begin
        w_addr = lmrws_pkg::PAGE_SEL_REG;
        w_data = {5'd0, p_high ? lmrws_pkg::PAGE_PWM_HI : lmrws_pkg::PAGE_PWM_LO};
      end
      lmrws_pkg::ST_SEL2: begin
        w_addr = lmrws_pkg::PAGE_SEL_REG;
        w_data = {5'd0, p_high ? lmrws_pkg::PAGE_SCL_HI : lmrws_pkg::PAGE_SCL_LO};
      end
      lmrws_pkg::ST_PWM: begin
        w_addr = p_addr;
        w_data = p_pwm;
      end
      lmrws_pkg::ST_SCALE: begin
        w_addr = p_addr;
        w_data = p_scl;
        w_last = 1'b1;
      end
      lmrws_pkg::ST_SINGLE: begin
        w_valid = 1'b0;
        w_error = p_err;
        w_last  = 1'b1;
      end
      default: begin
        w_valid = 1'b0;
      end
    endcase

    if (emit) begin
      case (state)
        lmrws_pkg::ST_UNLOCK1: state_next = lmrws_pkg::ST_SEL1;
        lmrws_pkg::ST_SEL1:    state_next = lmrws_pkg::ST_PWM;
        lmrws_pkg::ST_PWM:     state_next = lmrws_pkg::ST_UNLOCK2;
        lmrws_pkg::ST_UNLOCK2: state_next = lmrws_pkg::ST_SEL2;
        lmrws_pkg::ST_SEL2:    state_next = lmrws_pkg::ST_SCALE;
        default:               state_next = lmrws_pkg::ST_IDLE;
      endcase
    end
    if (load) begin
      state_next = first_step;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (emit) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      rsp.write_valid <= w_valid;
      rsp.reg_addr    <= w_addr;
      rsp.reg_data    <= w_data;
      rsp.error       <= w_error;
      rsp.last        <= w_last;
    end
  end

  a_page_after_write: assert property (@(posedge clk) disable iff (rst)
    load && !dec.err && !dec.empty |=>
      (current_page == lmrws_pkg::PAGE_SCL_LO) || (current_page == lmrws_pkg::PAGE_SCL_HI))
    else $error("tracked page not a scale page after a write request");

  a_sel2_data: assert property (@(posedge clk) disable iff (rst)
    emit && (state == lmrws_pkg::ST_SEL2) |=>
      (rsp.reg_data == 8'd2) || (rsp.reg_data == 8'd3))
    else $error("second page select does not name a scale page");

  a_error_word: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.error |-> !rsp.write_valid && rsp.last)
    else $error("error word carries a write or is not last");

  a_load_empty_stage: assert property (@(posedge clk) disable iff (rst)
    load && !(req.valid && req.ready) |=> !in_full)
    else $error("input stage still full after handing off its request");

endmodule

/* tb/lmrws_write_checker.sv */
`timescale 1ns / 1ps
module lmrws_write_checker (
  input  logic        clk,
  input  logic        rst,
  lmrws_req_if        req,
  lmrws_rsp_if        rsp,
  output int          fail_count,
  output int          words_pending
);
  import lmrws_pkg::*;

  typedef struct packed {
    logic       write_valid;
    logic [7:0] reg_addr;
    logic [7:0] reg_data;
    logic       error;
    logic       last;
  } write_word_t;

  write_word_t expected_writes[$];
  write_word_t want;
  write_word_t got;
  logic [2:0]  tracked_page = PAGE_CONFIG;

  function automatic int panel_row(input logic [3:0] row);
    int r;
    case (row)
      4'd0: r = 8;
      4'd1: r = 5;
      4'd2: r = 4;
      4'd3: r = 3;
      4'd4: r = 2;
      4'd5: r = 1;
      4'd6: r = 0;
      4'd7: r = 7;
      default: r = 6;
    endcase
    return r;
  endfunction

  function automatic logic [8:0] pixel_led(input logic [3:0] column, input logic [3:0] row,
                                           input logic [1:0] color);
    int r;
    int base;
    int pos;
    r = panel_row(row);
    if (column < NARROW_COLS) begin
      base = column + r * 10;
    end else begin
      base = column + WIDE_BASE + r * 3;
    end
    base = base * 3;
    pos = 2 - color;
    // odd columns and the last column have red/green/blue wired in another order
    if (column[0] || column == MAX_COLUMN) begin
      case (pos)
        0: pos = 2;
        1: pos = 0;
        default: pos = 1;
      endcase
    end
    return 9'(base + pos);
  endfunction

  function automatic write_word_t make_word(input logic wv, input logic [7:0] addr,
                                            input logic [7:0] data, input logic err,
                                            input logic fin);
    return {wv, addr, data, err, fin};
  endfunction

  task automatic select_page(input logic [2:0] page);
    if (tracked_page != page) begin
      tracked_page = page;
      expected_writes.push_back(make_word(1'b1, UNLOCK_REG, UNLOCK_KEY, 1'b0, 1'b0));
      expected_writes.push_back(make_word(1'b1, PAGE_SEL_REG, {5'd0, page}, 1'b0, 1'b0));
    end
  endtask

  task automatic predict_led_writes();
    logic [8:0] idx;
    logic [8:0] offset;
    logic [7:0] pwm;
    logic [7:0] scl;
    logic [2:0] pwm_page;
    logic [2:0] scl_page;
    if ((req.op == OP_PIXEL && (req.column > MAX_COLUMN || req.row > MAX_ROW)) ||
        (req.op == OP_RAW && req.led_index >= LED_COUNT)) begin
      expected_writes.push_back(make_word(1'b0, 8'd0, 8'd0, 1'b1, 1'b1));
      return;
    end
    if (req.op == OP_PIXEL && req.color == COLOR_NONE) begin
      expected_writes.push_back(make_word(1'b0, 8'd0, 8'd0, 1'b0, 1'b1));
      return;
    end
    if (req.op == OP_PIXEL) begin
      idx = pixel_led(req.column, req.row, req.color);
      pwm = req.brightness;
      scl = req.brightness;
    end else begin
      idx = req.led_index;
      pwm = req.pwm_level;
      scl = req.current_scale;
    end
    if (idx >= LOW_BANK_SIZE) begin
      offset   = idx - LOW_BANK_SIZE;
      pwm_page = PAGE_PWM_HI;
      scl_page = PAGE_SCL_HI;
    end else begin
      offset   = idx;
      pwm_page = PAGE_PWM_LO;
      scl_page = PAGE_SCL_LO;
    end
    select_page(pwm_page);
    expected_writes.push_back(make_word(1'b1, offset[7:0], pwm, 1'b0, 1'b0));
    select_page(scl_page);
    expected_writes.push_back(make_word(1'b1, offset[7:0], scl, 1'b0, 1'b1));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      tracked_page = PAGE_CONFIG;
      expected_writes.delete();
    end else begin
      if (req.valid && req.ready) begin
        predict_led_writes();
      end
      if (rsp.valid && rsp.ready) begin
        got = {rsp.write_valid, rsp.reg_addr, rsp.reg_data, rsp.error, rsp.last};
        if (expected_writes.size() == 0) begin
          $display("%0t: unexpected word, expected none, actual wv=%0b addr=%h data=%h err=%0b last=%0b",
                   $time, got.write_valid, got.reg_addr, got.reg_data, got.error, got.last);
          fail_count++;
        end else begin
          want = expected_writes.pop_front();
          if (want != got) begin
            $display("%0t: word mismatch, expected wv=%0b addr=%h data=%h err=%0b last=%0b",
                     $time, want.write_valid, want.reg_addr, want.reg_data, want.error,
                     want.last);
            $display("%0t:                 actual wv=%0b addr=%h data=%h err=%0b last=%0b",
                     $time, got.write_valid, got.reg_addr, got.reg_data, got.error, got.last);
            fail_count++;
          end
        end
      end
    end
    words_pending = expected_writes.size();
  end

endmodule

/* tb/led_matrix_register_write_sequencer_unit_tb.sv */
`timescale 1ns / 1ps
module led_matrix_register_write_sequencer_unit_tb;
  import lmrws_pkg::*;

  localparam int         CYCLE_LIMIT      = 200000;
  localparam int         HOLD_CYCLES      = 300;
  localparam int         RANDOM_PER_PHASE = 35;
  localparam int         DRAIN_CYCLES     = 20;
  localparam logic [1:0] COLOR_GREEN      = 2'd1;
  localparam logic [1:0] COLOR_BLUE       = 2'd2;

  logic clk = 1'b0;
  logic rst = 1'b1;

  int fail_count;
  int words_pending;
  int send_idle_pct = 0;
  int sink_stall_pct = 0;
  int hold_requests = 0;
  int holds_served = 0;
  int hold_left = 0;
  int cycle_count = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  lmrws_req_if req ();
  lmrws_rsp_if rsp ();

  led_matrix_register_write_sequencer_unit u_dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  lmrws_write_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .req           (req),
    .rsp           (rsp),
    .fail_count    (fail_count),
    .words_pending (words_pending)
  );

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("led_matrix_register_write_sequencer_unit: mismatch");
      $finish;
    end
  end

  // result side: random stalls, plus long hold-offs on request
  initial begin
    rsp.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_requests != holds_served) begin
        holds_served++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  // called at a falling edge, returns at the falling edge after the word is taken
  task automatic send_request(input logic op, input logic [3:0] column, input logic [3:0] row,
                              input logic [1:0] color, input logic [7:0] brightness,
                              input logic [8:0] led_index, input logic [7:0] pwm_level,
                              input logic [7:0] current_scale);
    while ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(negedge clk);
    end
    req.valid         <= 1'b1;
    req.op            <= op;
    req.column        <= column;
    req.row           <= row;
    req.color         <= color;
    req.brightness    <= brightness;
    req.led_index     <= led_index;
    req.pwm_level     <= pwm_level;
    req.current_scale <= current_scale;
    do @(posedge clk); while (!req.ready);
    @(negedge clk);
  endtask

  task automatic send_random_request();
    logic       op;
    logic [3:0] column;
    logic [3:0] row;
    logic [1:0] color;
    logic [8:0] led_index;
    op        = 1'($urandom_range(1));
    column    = ($urandom_range(9) == 0) ? 4'($urandom_range(15, 13)) : 4'($urandom_range(12));
    row       = ($urandom_range(9) == 0) ? 4'($urandom_range(15, 9)) : 4'($urandom_range(8));
    color     = ($urandom_range(9) == 0) ? COLOR_NONE : 2'($urandom_range(2));
    led_index = ($urandom_range(9) == 0) ? 9'($urandom_range(511, 351))
                                         : 9'($urandom_range(350));
    send_request(op, column, row, color, 8'($urandom), led_index, 8'($urandom), 8'($urandom));
  endtask

  initial begin
    req.valid         = 1'b0;
    req.op            = OP_PIXEL;
    req.column        = 4'd0;
    req.row           = 4'd0;
    req.color         = COLOR_RED;
    req.brightness    = 8'd0;
    req.led_index     = 9'd0;
    req.pwm_level     = 8'd0;
    req.current_scale = 8'd0;
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    // corners of the pixel map, both column groups, swapped color order
    send_request(OP_PIXEL, 4'd0, 4'd0, COLOR_RED, 8'hFF, 9'h1FF, 8'hFF, 8'hFF);
    send_request(OP_PIXEL, 4'd12, 4'd8, COLOR_BLUE, 8'h00, 9'h000, 8'h00, 8'h00);
    send_request(OP_PIXEL, 4'd10, 4'd6, COLOR_GREEN, 8'h5A, 9'h155, 8'hAA, 8'h55);
    send_request(OP_PIXEL, 4'd11, 4'd1, COLOR_RED, 8'hA5, 9'h0AA, 8'h55, 8'hAA);
    send_request(OP_PIXEL, 4'd9, 4'd7, COLOR_BLUE, 8'h01, 9'h000, 8'h00, 8'h00);
    send_request(OP_PIXEL, 4'd1, 4'd3, COLOR_GREEN, 8'h80, 9'h000, 8'h00, 8'h00);
    send_request(OP_PIXEL, 4'd2, 4'd4, COLOR_RED, 8'h7F, 9'h000, 8'h00, 8'h00);
    send_request(OP_PIXEL, 4'd12, 4'd0, COLOR_GREEN, 8'h33, 9'h000, 8'h00, 8'h00);
    // out of range pixels, no-LED color, and range check taking priority
    send_request(OP_PIXEL, 4'd13, 4'd0, COLOR_RED, 8'h11, 9'h000, 8'h00, 8'h00);
    send_request(OP_PIXEL, 4'd15, 4'd15, COLOR_BLUE, 8'hFF, 9'h1FF, 8'hFF, 8'hFF);
    send_request(OP_PIXEL, 4'd0, 4'd9, COLOR_GREEN, 8'h22, 9'h000, 8'h00, 8'h00);
    send_request(OP_PIXEL, 4'd5, 4'd2, COLOR_NONE, 8'h44, 9'h000, 8'h00, 8'h00);
    send_request(OP_PIXEL, 4'd14, 4'd2, COLOR_NONE, 8'h44, 9'h000, 8'h00, 8'h00);
    // raw writes at bank edges
    send_request(OP_RAW, 4'd15, 4'd15, COLOR_NONE, 8'hFF, 9'd0, 8'h00, 8'hFF);
    send_request(OP_RAW, 4'd0, 4'd0, COLOR_RED, 8'h00, 9'd179, 8'hFF, 8'h00);
    send_request(OP_RAW, 4'd0, 4'd0, COLOR_RED, 8'h00, 9'd180, 8'h12, 8'h34);
    send_request(OP_RAW, 4'd0, 4'd0, COLOR_RED, 8'h00, 9'd350, 8'hFF, 8'hFF);
    send_request(OP_RAW, 4'd0, 4'd0, COLOR_RED, 8'h00, 9'd180, 8'h56, 8'h78);
    send_request(OP_RAW, 4'd0, 4'd0, COLOR_RED, 8'h00, 9'd256, 8'h9A, 8'hBC);
    send_request(OP_RAW, 4'd0, 4'd0, COLOR_RED, 8'h00, 9'd351, 8'hDE, 8'hF0);
    send_request(OP_RAW, 4'd0, 4'd0, COLOR_RED, 8'h00, 9'd511, 8'hFF, 8'hFF);
    send_request(OP_RAW, 4'd0, 4'd0, COLOR_RED, 8'h00, 9'd1, 8'h01, 8'h02);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 0;
          sink_stall_pct = 0;
          hold_requests++;   // long back-pressure while the sender keeps pushing
        end
        1: begin
          send_idle_pct  = 53;
          sink_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          sink_stall_pct = 53;
        end
        default: begin
          send_idle_pct  = 9;
          sink_stall_pct = 9;
        end
      endcase
      repeat (RANDOM_PER_PHASE) send_random_request();
    end
    req.valid <= 1'b0;

    while (words_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("led_matrix_register_write_sequencer_unit: match");
    end else begin
      $display("led_matrix_register_write_sequencer_unit: mismatch");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/lmrws_pkg.sv
design/lmrws_req_if.sv
design/lmrws_rsp_if.sv
design/lmrws_led_map.sv
design/led_matrix_register_write_sequencer_unit.sv
tb/lmrws_write_checker.sv
tb/led_matrix_register_write_sequencer_unit_tb.sv
